// File: rtl/core/pact_pkg.sv
// Shared types and constants for the per-address connection throttle.
// No dependencies; imported by the top level and by the checker.
package pact_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int KEY_W   = 64;
    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd1;

    // Commands carried in s_tuser
    localparam logic CMD_CONNECT = 1'b0;
    localparam logic CMD_COLLECT = 1'b1;

    // Verdict codes
    localparam logic [2:0] VERDICT_EXEMPT  = 3'd0;
    localparam logic [2:0] VERDICT_NEW     = 3'd1;
    localparam logic [2:0] VERDICT_COUNTED = 3'd2;
    localparam logic [2:0] VERDICT_DENIED  = 3'd3;
    localparam logic [2:0] VERDICT_COLLECT = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/core/pact_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/per_address_connection_throttle_top.sv
// Flow: an exempt connect goes from ST_IDLE straight to ST_FINISH and then into the output
// register; a tracked connect or a collect sweeps the entry RAM in ST_SCAN (one read a
// cycle), checks the last read data in ST_WAIT, decides and writes back in ST_DECIDE, and
// hands the result over in ST_FINISH. One transaction at a time (s_tready only in ST_IDLE);
// the sweep uses the single read port of the entry RAM. Reset (aresetn low, synchronous) clears
// all valid bits at once and loads max_attempts = 1 and window_seconds = 1; no clearing pass is needed.
module per_address_connection_throttle_top
    import pact_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Input transactions
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [63:0] addr_high, [127:64] addr_low, [159:128] now_seconds, [160] exempt,
    // [161] is_tls, [167:162] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                  s_tuser,
    // Result transactions
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] verdict, [3] send_error, [4] table_full, [7:5] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // wait for a transaction
    localparam logic [2:0] ST_SCAN   = 3'd1;  // issue one RAM read a cycle
    localparam logic [2:0] ST_WAIT   = 3'd2;  // last read data is being checked
    localparam logic [2:0] ST_DECIDE = 3'd3;  // pick the verdict, write the entry back
    localparam logic [2:0] ST_FINISH = 3'd4;  // hand the result to the output register

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [2:0] state_reg, state_next;

    // Configuration registers
    logic [CFG_W-1:0] max_attempts_reg, window_seconds_reg;

    // Latched input item
    logic              cmd_reg;
    logic [KEY_W-1:0]  key_high_reg, key_low_reg;
    logic [TIME_W-1:0] now_reg;
    logic              tls_reg;

    // Valid bits, one flip-flop per entry
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    // Sweep pointer and the read-data tag registered from it
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;

    // Search results gathered during the sweep
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hit_live_reg, hit_live_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic [TIME_W-1:0]  hit_start_reg, hit_start_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               stale_found_reg, stale_found_next;
    logic [IDX_W-1:0]   stale_idx_reg, stale_idx_next;

    // Pending result and output register
    logic [2:0] res_verdict_reg, res_verdict_next;
    logic       res_err_reg, res_err_next;
    logic       res_full_reg, res_full_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_verdict_reg;
    logic       m_err_reg, m_full_reg;
    logic       m_load;

    // Entry RAM ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    logic              chk_entry_valid, chk_live, chk_match;
    logic [TIME_W-1:0] chk_age;
    logic              in_accept;

    pact_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign ram_raddr = scan_idx_reg;

    // Examine the entry whose read data just came back: age wraps modulo 2^32
    assign chk_entry_valid = valid_reg[chk_idx_reg];
    assign chk_age         = now_reg - ram_rdata.start;
    assign chk_live        = chk_age < {{(TIME_W-CFG_W){1'b0}}, window_seconds_reg};
    assign chk_match       = (ram_rdata.key_high == key_high_reg) &&
                             (ram_rdata.key_low == key_low_reg);

    always_comb begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        scan_idx_next    = scan_idx_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = scan_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_live_next    = hit_live_reg;
        hit_count_next   = hit_count_reg;
        hit_start_next   = hit_start_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        stale_found_next = stale_found_reg;
        stale_idx_next   = stale_idx_reg;
        res_verdict_next = res_verdict_reg;
        res_err_next     = res_err_reg;
        res_full_next    = res_full_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_idx_reg;
        ram_wdata        = '{key_high: key_high_reg, key_low: key_low_reg,
                             count: COUNT_W'(1), start: now_reg};
        m_load           = 1'b0;

        // Fold the checked entry into the search, or on collect drop it once it has expired
        if (chk_valid_reg) begin
            if (cmd_reg == CMD_COLLECT) begin
                if (chk_entry_valid && !chk_live) begin
                    valid_next[chk_idx_reg] = 1'b0;
                end
            end else if (chk_entry_valid) begin
                if (!hit_found_reg && chk_match) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = chk_idx_reg;
                    hit_live_next  = chk_live;
                    hit_count_next = ram_rdata.count;
                    hit_start_next = ram_rdata.start;
                end
                if (!stale_found_reg && !chk_live) begin
                    stale_found_next = 1'b1;
                    stale_idx_next   = chk_idx_reg;
                end
            end else if (!free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    res_verdict_next = VERDICT_EXEMPT;
                    res_err_next     = 1'b0;
                    res_full_next    = 1'b0;
                    hit_found_next   = 1'b0;
                    free_found_next  = 1'b0;
                    stale_found_next = 1'b0;
                    scan_idx_next    = '0;
                    if (s_tuser == CMD_CONNECT && s_tdata[160]) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                chk_valid_next = 1'b1;
                chk_idx_next   = scan_idx_reg;
                if (scan_idx_reg == IDX_LAST) begin
                    state_next = ST_WAIT;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next       = ST_FINISH;
                res_verdict_next = VERDICT_NEW;
                if (cmd_reg == CMD_COLLECT) begin
                    res_verdict_next = VERDICT_COLLECT;
                end else if (hit_found_reg) begin
                    if (hit_live_reg) begin
                        if (hit_count_reg >= max_attempts_reg) begin
                            res_verdict_next = VERDICT_DENIED;
                            res_err_next     = !tls_reg;
                        end else begin
                            // Count the attempt, keep the window start
                            res_verdict_next = VERDICT_COUNTED;
                            ram_we          = 1'b1;
                            ram_wdata.count = hit_count_reg + 1'b1;
                            ram_wdata.start = hit_start_reg;
                        end
                    end else begin
                        ram_we = 1'b1;
                    end
                end else if (free_found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = free_idx_reg;
                end else if (stale_found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = stale_idx_reg;
                end else begin
                    res_full_next = 1'b1;
                end
                if (ram_we) begin
                    valid_next[ram_waddr] = 1'b1;
                end
            end
            ST_FINISH: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_load ? 1'b1 : (m_valid_reg && !m_tready);
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            valid_reg          <= '0;
            chk_valid_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
            max_attempts_reg   <= CFG_W'(1);
            window_seconds_reg <= CFG_W'(1);
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_MAX_ATTEMPTS:   max_attempts_reg   <= cfg_wdata;
                    CFG_WINDOW_SECONDS: window_seconds_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload and search registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg      <= s_tuser;
            key_high_reg <= s_tdata[63:0];
            key_low_reg  <= s_tdata[127:64];
            now_reg      <= s_tdata[159:128];
            tls_reg      <= s_tdata[161];
        end
        scan_idx_reg    <= scan_idx_next;
        chk_idx_reg     <= chk_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_live_reg    <= hit_live_next;
        hit_count_reg   <= hit_count_next;
        hit_start_reg   <= hit_start_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        stale_found_reg <= stale_found_next;
        stale_idx_reg   <= stale_idx_next;
        res_verdict_reg <= res_verdict_next;
        res_err_reg     <= res_err_next;
        res_full_reg    <= res_full_next;
        if (m_load) begin
            m_verdict_reg <= res_verdict_reg;
            m_err_reg     <= res_err_reg;
            m_full_reg    <= res_full_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_full_reg, m_err_reg, m_verdict_reg};

endmodule

// File: rtl/core/pact_checker.sv
// Port-level checks for the per-address connection throttle, bound to the top level.
// Depends on pact_pkg.
module pact_checker
    import pact_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result waiting on the output holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An error line goes out only with a denial
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == VERDICT_DENIED)
        else $error("send_error without denial");

    // A full table is reported only on a new, untracked connection
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[2:0] == VERDICT_NEW && !m_tdata[3])
        else $error("table_full with wrong verdict");

endmodule

bind per_address_connection_throttle_top pact_checker u_pact_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
